// ===== hdl/kf2s_pkg.sv =====
`default_nettype none
package kf2s_pkg;

   localparam int unsigned QW = 32;
   localparam int unsigned PW = 64;
   localparam int unsigned FRAC = 16;
   localparam int unsigned NUM_REGS = 8;
   localparam int unsigned IDX_W = 3;
   localparam int unsigned DIV_W = 49;

   localparam logic [IDX_W-1:0] REG_TRANS_A = 3'd0;
   localparam logic [IDX_W-1:0] REG_TRANS_B = 3'd1;
   localparam logic [IDX_W-1:0] REG_TRANS_C = 3'd2;
   localparam logic [IDX_W-1:0] REG_TRANS_D = 3'd3;
   localparam logic [IDX_W-1:0] REG_NOISE_POS = 3'd4;
   localparam logic [IDX_W-1:0] REG_NOISE_CROSS = 3'd5;
   localparam logic [IDX_W-1:0] REG_NOISE_RATE = 3'd6;
   localparam logic [IDX_W-1:0] REG_MEAS_NOISE = 3'd7;

   // Operand selects for the shared multiplier.
   typedef enum logic [3:0] {
      OP_A, OP_B, OP_C, OP_D, OP_XP, OP_XR, OP_P00, OP_P01, OP_P10, OP_P11,
      OP_F0, OP_F1, OP_F2, OP_F3, OP_K0, OP_K1
   } opnd_type;

   // Accumulator actions.
   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
   } acc_op_type;

   // Destination of a finished, saturated sum.
   typedef enum logic [3:0] {
      DST_NONE, DST_XP0, DST_XP1, DST_F0, DST_F1, DST_F2, DST_F3,
      DST_P00, DST_P01, DST_P10, DST_P11, DST_POS, DST_RATE
   } dst_type;

   // Value loaded into the accumulator before products are added or subtracted.
   typedef enum logic [3:0] {
      BASE_ZERO, BASE_NPOS, BASE_NCROSS, BASE_NRATE, BASE_XP0, BASE_XP1, BASE_INNOV,
      BASE_P00, BASE_P01, BASE_P10, BASE_P11
   } base_type;

   typedef struct packed {
      opnd_type   mul_a;
      opnd_type   mul_b;
      logic       mul_en;
      acc_op_type acc_op;
      base_type   base;
      dst_type    dst;
      logic       commit;
      logic       div_start;
      logic       div_sel;
      logic       load_z;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic fault;
   } sts_type;

   function automatic logic signed [QW-1:0] sat32(input logic signed [PW+1:0] v);
      logic signed [PW+1:0] hi;
      logic signed [PW+1:0] lo;
      hi = (PW+2)'(signed'({1'b0, {(QW-1){1'b1}}}));
      lo = -hi - (PW+2)'(1);
      if (v > hi) begin
         sat32 = {1'b0, {(QW-1){1'b1}}};
      end else if (v < lo) begin
         sat32 = {1'b1, {(QW-1){1'b0}}};
      end else begin
         sat32 = v[QW-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/kf2s_div.sv =====
`default_nettype none
module kf2s_div
   import kf2s_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic signed [QW-1:0]  numer,
   input  wire logic signed [QW:0]    denom,
   output logic                       busy,
   output logic signed [QW-1:0]       quot
);

   localparam int unsigned CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] q_ff, q_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [QW:0]      den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W-1:0] shifted;
   logic signed [DIV_W+1:0] sq;
   logic [QW:0]      numer_mag;

   always_comb begin
      numer_mag = numer[QW-1] ? (QW+1)'(-{numer[QW-1], numer}) : {1'b0, numer};
      rem_in = rem_ff;
      q_in = q_ff;
      num_in = num_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[DIV_W-2:0], num_ff[DIV_W-1]};
      trial = {1'b0, shifted} - (DIV_W+1)'(den_ff);
      if (start) begin
         rem_in = '0;
         q_in = '0;
         num_in = {numer_mag, {FRAC{1'b0}}};
         den_in = denom[QW] ? (QW+1)'(-denom) : denom;
         neg_in = numer[QW-1] ^ denom[QW];
         cnt_in = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            q_in = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      num_ff <= num_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      sq = neg_ff ? -(DIV_W+2)'({2'b00, q_ff}) : (DIV_W+2)'({2'b00, q_ff});
      quot = sat32((PW+2)'(sq));
   end

   assign busy = busy_ff;

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0) else $error("divider count not zero when idle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_den_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> $stable(den_ff)) else $error("divisor changed");

endmodule
`default_nettype wire

// ===== hdl/kf2s_datapath.sv =====
`default_nettype none
module kf2s_datapath
   import kf2s_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [IDX_W-1:0]      csr_index,
   input  wire logic [QW-1:0]         csr_data,
   input  wire logic signed [QW-1:0]  req_sample,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   output logic signed [QW-1:0]       pos,
   output logic signed [QW-1:0]       rate
);

   logic signed [QW-1:0] ta_ff, tb_ff, tc_ff, td_ff, ncross_ff;
   logic [QW-2:0]        npos_ff, nrate_ff, rnoise_ff;
   logic signed [QW-1:0] pos_ff, rate_ff, xp0_ff, xp1_ff, z_ff;
   logic signed [QW-1:0] p_ff [4];
   logic signed [QW-1:0] f_ff [4];
   logic signed [QW-1:0] k0_ff, k1_ff;
   logic                 fault_ff;
   logic signed [PW-1:0] prod_ff;
   logic                 prod_v_ff;
   logic signed [PW+1:0] acc_ff, acc_in;
   logic signed [QW-1:0] opa, opb, sat_val, quot;
   logic signed [PW-1:0] rnd;
   logic signed [PW+1:0] base_v;
   logic signed [QW:0]   s_val;
   logic                 div_busy;
   logic                 div_sel_ff;
   logic                 div_was_busy_ff;

   function automatic logic signed [QW-1:0] pick(input opnd_type o,
      input logic signed [QW-1:0] a, b, c, d, xp, xr, p0, p1, p2, p3,
      f0, f1, f2, f3, k0, k1);
      case (o)
         OP_A: pick = a;
         OP_B: pick = b;
         OP_C: pick = c;
         OP_D: pick = d;
         OP_XP: pick = xp;
         OP_XR: pick = xr;
         OP_P00: pick = p0;
         OP_P01: pick = p1;
         OP_P10: pick = p2;
         OP_P11: pick = p3;
         OP_F0: pick = f0;
         OP_F1: pick = f1;
         OP_F2: pick = f2;
         OP_F3: pick = f3;
         OP_K0: pick = k0;
         OP_K1: pick = k1;
         default: pick = '0;
      endcase
   endfunction

   always_comb begin
      opa = pick(cmd.mul_a, ta_ff, tb_ff, tc_ff, td_ff, pos_ff, rate_ff, p_ff[0],
         p_ff[1], p_ff[2], p_ff[3], f_ff[0], f_ff[1], f_ff[2], f_ff[3], k0_ff, k1_ff);
      opb = pick(cmd.mul_b, ta_ff, tb_ff, tc_ff, td_ff, pos_ff, rate_ff, p_ff[0],
         p_ff[1], p_ff[2], p_ff[3], f_ff[0], f_ff[1], f_ff[2], f_ff[3], k0_ff, k1_ff);
      rnd = (prod_ff + PW'(32768)) >>> FRAC;
      case (cmd.base)
         BASE_ZERO: base_v = '0;
         BASE_NPOS: base_v = (PW+2)'({1'b0, npos_ff});
         BASE_NCROSS: base_v = (PW+2)'(ncross_ff);
         BASE_NRATE: base_v = (PW+2)'({1'b0, nrate_ff});
         BASE_XP0: base_v = (PW+2)'(xp0_ff);
         BASE_XP1: base_v = (PW+2)'(xp1_ff);
         BASE_INNOV: base_v = (PW+2)'(z_ff) - (PW+2)'(xp0_ff);
         BASE_P00: base_v = (PW+2)'(p_ff[0]);
         BASE_P01: base_v = (PW+2)'(p_ff[1]);
         BASE_P10: base_v = (PW+2)'(p_ff[2]);
         BASE_P11: base_v = (PW+2)'(p_ff[3]);
         default: base_v = '0;
      endcase
      acc_in = acc_ff;
      case (cmd.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = base_v;
         ACC_ADD: acc_in = acc_ff + (prod_v_ff ? (PW+2)'(rnd) : '0);
         ACC_SUB: acc_in = acc_ff - (prod_v_ff ? (PW+2)'(rnd) : '0);
         default: acc_in = acc_ff;
      endcase
      sat_val = sat32(acc_ff);
      s_val = (QW+1)'(p_ff[0]) + (QW+1)'({1'b0, rnoise_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff <= 32'sd13;
         tb_ff <= '0;
         tc_ff <= '0;
         td_ff <= 32'sd65536;
         npos_ff <= 31'd7;
         ncross_ff <= 32'sd328;
         nrate_ff <= 31'd16384;
         rnoise_ff <= 31'd26214;
         pos_ff <= '0;
         rate_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            p_ff[i] <= '0;
         end
         prod_v_ff <= 1'b0;
         fault_ff <= 1'b0;
         div_was_busy_ff <= 1'b0;
      end else begin
         prod_v_ff <= cmd.mul_en;
         div_was_busy_ff <= div_busy;
         if (csr_write) begin
            case (csr_index)
               REG_TRANS_A: ta_ff <= csr_data;
               REG_TRANS_B: tb_ff <= csr_data;
               REG_TRANS_C: tc_ff <= csr_data;
               REG_TRANS_D: td_ff <= csr_data;
               REG_NOISE_POS: npos_ff <= csr_data[QW-2:0];
               REG_NOISE_CROSS: ncross_ff <= csr_data;
               REG_NOISE_RATE: nrate_ff <= csr_data[QW-2:0];
               REG_MEAS_NOISE: rnoise_ff <= csr_data[QW-2:0];
               default: ;
            endcase
         end
         if (cmd.div_start) begin
            fault_ff <= (s_val == '0);
         end
         if (cmd.commit) begin
            case (cmd.dst)
               DST_POS: pos_ff <= sat_val;
               DST_RATE: rate_ff <= sat_val;
               DST_P00: p_ff[0] <= sat_val;
               DST_P01: p_ff[1] <= sat_val;
               DST_P10: p_ff[2] <= sat_val;
               DST_P11: p_ff[3] <= sat_val;
               default: ;
            endcase
         end
      end
      prod_ff <= PW'(opa) * PW'(opb);
      acc_ff <= acc_in;
      if (cmd.load_z) begin
         z_ff <= req_sample;
      end
      if (cmd.div_start) begin
         div_sel_ff <= cmd.div_sel;
      end
      if (div_was_busy_ff && !div_busy) begin
         if (fault_ff) begin
            if (div_sel_ff) k1_ff <= '0; else k0_ff <= '0;
         end else begin
            if (div_sel_ff) k1_ff <= quot; else k0_ff <= quot;
         end
      end
      if (cmd.commit) begin
         case (cmd.dst)
            DST_XP0: xp0_ff <= sat_val;
            DST_XP1: xp1_ff <= sat_val;
            DST_F0: f_ff[0] <= sat_val;
            DST_F1: f_ff[1] <= sat_val;
            DST_F2: f_ff[2] <= sat_val;
            DST_F3: f_ff[3] <= sat_val;
            default: ;
         endcase
      end
   end

   // Gain numerators are the predicted P00 and P10 held in the covariance file.
   kf2s_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (cmd.div_sel ? p_ff[2] : p_ff[0]),
      .denom (s_val),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign sts.div_busy = div_busy | div_was_busy_ff;
   assign sts.fault = fault_ff;
   assign pos = pos_ff;
   assign rate = rate_ff;

   a_commit_known: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> cmd.dst != DST_NONE) else $error("commit without target");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy) else $error("divider restarted while busy");
   a_prod_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en |=> prod_v_ff) else $error("product valid lost");

endmodule
`default_nettype wire

// ===== hdl/kf2s_ctrl.sv =====
`default_nettype none
module kf2s_ctrl
   import kf2s_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   input  wire sts_type sts,
   output cmd_type    cmd
);

   // Each sum: load base, issue products, add the last, commit.
   typedef enum logic [1:0] {
      ST_IDLE, ST_RUN, ST_DIV, ST_DONE
   } state_type;

   localparam int unsigned NSTEP = 18;
   localparam int unsigned STEP_W = $clog2(NSTEP);

   typedef struct packed {
      opnd_type a0, b0, a1, b1;
      logic     two;
      logic     neg;
      base_type base;
      dst_type  dst;
      logic     div_after;
   } step_type;

   function automatic step_type step_rom(input logic [STEP_W-1:0] i);
      step_type s;
      s = '{OP_A, OP_XP, OP_B, OP_XR, 1'b1, 1'b0, BASE_ZERO, DST_XP0, 1'b0};
      case (i)
         0: s = '{OP_A, OP_XP, OP_B, OP_XR, 1'b1, 1'b0, BASE_ZERO, DST_XP0, 1'b0};
         1: s = '{OP_C, OP_XP, OP_D, OP_XR, 1'b1, 1'b0, BASE_ZERO, DST_XP1, 1'b0};
         2: s = '{OP_A, OP_P00, OP_B, OP_P10, 1'b1, 1'b0, BASE_ZERO, DST_F0, 1'b0};
         3: s = '{OP_A, OP_P01, OP_B, OP_P11, 1'b1, 1'b0, BASE_ZERO, DST_F1, 1'b0};
         4: s = '{OP_C, OP_P00, OP_D, OP_P10, 1'b1, 1'b0, BASE_ZERO, DST_F2, 1'b0};
         5: s = '{OP_C, OP_P01, OP_D, OP_P11, 1'b1, 1'b0, BASE_ZERO, DST_F3, 1'b0};
         6: s = '{OP_F0, OP_A, OP_F1, OP_B, 1'b1, 1'b0, BASE_NPOS, DST_P00, 1'b0};
         7: s = '{OP_F0, OP_C, OP_F1, OP_D, 1'b1, 1'b0, BASE_NCROSS, DST_P01, 1'b0};
         8: s = '{OP_F2, OP_A, OP_F3, OP_B, 1'b1, 1'b0, BASE_NCROSS, DST_P10, 1'b0};
         9: s = '{OP_F2, OP_C, OP_F3, OP_D, 1'b1, 1'b0, BASE_NRATE, DST_P11, 1'b1};
         10: s = '{OP_A, OP_A, OP_A, OP_A, 1'b0, 1'b0, BASE_INNOV, DST_F0, 1'b0};
         11: s = '{OP_F0, OP_F0, OP_F0, OP_F0, 1'b0, 1'b0, BASE_XP0, DST_F0, 1'b0};
         default: s = '{OP_A, OP_A, OP_A, OP_A, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 1'b0};
      endcase
      return s;
   endfunction

   state_type state_ff;
   logic [4:0] step_ff;
   logic [2:0] ph_ff;
   logic       dsel_ff;
   logic       rsp_valid_ff;

   // Post-gain sums, each a base and one signed product.
   typedef struct packed {
      opnd_type a;
      opnd_type b;
      logic     neg;
      base_type base;
      dst_type  dst;
   } upd_type;

   // The lower covariance row is updated first, since it reads the predicted
   // upper row.
   function automatic upd_type upd_rom(input logic [2:0] i);
      upd_type u;
      case (i)
         3'd0: u = '{OP_K0, OP_XP, 1'b0, BASE_XP0, DST_POS};
         3'd1: u = '{OP_K1, OP_XP, 1'b0, BASE_XP1, DST_RATE};
         3'd2: u = '{OP_K1, OP_P00, 1'b1, BASE_P10, DST_P10};
         3'd3: u = '{OP_K1, OP_P01, 1'b1, BASE_P11, DST_P11};
         3'd4: u = '{OP_K0, OP_P00, 1'b1, BASE_P00, DST_P00};
         default: u = '{OP_K0, OP_P01, 1'b1, BASE_P01, DST_P01};
      endcase
      return u;
   endfunction

   step_type cur;
   upd_type  up;

   always_comb begin
      cur = step_rom(step_ff[STEP_W-1:0]);
      up = upd_rom(step_ff[2:0]);
      cmd = '{OP_A, OP_A, 1'b0, ACC_HOLD, BASE_ZERO, DST_NONE, 1'b0, 1'b0, 1'b0, 1'b0};
      cmd.load_z = (state_ff == ST_IDLE) && req_valid;
      case (state_ff)
         ST_RUN: begin
            case (ph_ff)
               3'd0: begin
                  cmd.acc_op = ACC_LOAD;
                  cmd.base = cur.base;
                  cmd.mul_a = cur.a0;
                  cmd.mul_b = cur.b0;
                  cmd.mul_en = cur.two;
               end
               3'd1: begin
                  cmd.mul_a = cur.a1;
                  cmd.mul_b = cur.b1;
                  cmd.mul_en = cur.two;
                  cmd.acc_op = ACC_ADD;
               end
               3'd2: cmd.acc_op = ACC_ADD;
               default: begin
                  cmd.commit = 1'b1;
                  cmd.dst = cur.dst;
                  cmd.div_start = cur.div_after;
                  cmd.div_sel = 1'b0;
               end
            endcase
         end
         ST_DIV: begin
            if (!sts.div_busy && !dsel_ff) begin
               cmd.div_start = 1'b1;
               cmd.div_sel = 1'b1;
            end
            case (ph_ff)
               3'd0: begin
                  cmd.acc_op = ACC_LOAD;
                  cmd.base = up.base;
                  cmd.mul_a = up.a;
                  cmd.mul_b = (up.b == OP_XP) ? OP_F0 : up.b;
                  cmd.mul_en = 1'b1;
               end
               3'd1: cmd.acc_op = up.neg ? ACC_SUB : ACC_ADD;
               3'd2: ;
               default: begin
                  cmd.commit = 1'b1;
                  cmd.dst = up.dst;
               end
            endcase
         end
         default: ;
      endcase
   end

   logic upd_ready;
   assign upd_ready = dsel_ff && !sts.div_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         ph_ff <= '0;
         dsel_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  state_ff <= ST_RUN;
                  step_ff <= '0;
                  ph_ff <= '0;
               end
            end
            ST_RUN: begin
               if (ph_ff == 3'd3) begin
                  ph_ff <= '0;
                  step_ff <= step_ff + 5'd1;
                  if (step_ff == 5'd10) begin
                     state_ff <= ST_DIV;
                     dsel_ff <= 1'b0;
                  end
               end else begin
                  ph_ff <= ph_ff + 3'd1;
               end
            end
            ST_DIV: begin
               if (!sts.div_busy && !dsel_ff) begin
                  dsel_ff <= 1'b1;
                  step_ff <= '0;
                  ph_ff <= '0;
               end else if (upd_ready) begin
                  if (ph_ff == 3'd3) begin
                     ph_ff <= '0;
                     step_ff <= step_ff + 5'd1;
                     if (step_ff == 5'd5) begin
                        state_ff <= ST_DONE;
                     end
                  end else begin
                     ph_ff <= ph_ff + 3'd1;
                  end
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall) else $error("input taken while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid_ff) else $error("result not raised");
   a_ph_range: assert property (@(posedge clock) disable iff (reset)
      ph_ff <= 3'd3) else $error("phase out of range");

endmodule
`default_nettype wire

// ===== hdl/kalman_filter_two_state.sv =====
`default_nettype none
// Two-state Kalman filter in signed Q16.16: one position sample in, the updated
// position and rate estimates out, with a flag set when the innovation variance is
// zero. A single shared 32x32 multiplier performs eleven prediction sums and six
// update sums, and a bit-serial divider computes each of the two gain entries,
// the first overlapping the last prediction sum. A new item is taken only after
// the previous result has been delivered.
module kalman_filter_two_state
   import kf2s_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [QW-1:0] req_sample,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [QW-1:0]      rsp_est_position,
   output logic signed [QW-1:0]      rsp_est_rate,
   output logic                      rsp_gain_fault,
   input  wire logic                 csr_write,
   input  wire logic [IDX_W-1:0]     csr_index,
   input  wire logic [QW-1:0]        csr_data
);

   cmd_type cmd;
   sts_type sts;

   kf2s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kf2s_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_sample (req_sample),
      .cmd        (cmd),
      .sts        (sts),
      .pos        (rsp_est_position),
      .rate       (rsp_est_rate)
   );

   assign rsp_gain_fault = sts.fault;

endmodule
`default_nettype wire

// ===== sim/kf2s_checker.sv =====
`timescale 1ns / 100ps
module kf2s_checker
   import kf2s_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic signed [QW-1:0] req_sample,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic signed [QW-1:0] rsp_est_position,
   input  wire logic signed [QW-1:0] rsp_est_rate,
   input  wire logic                 rsp_gain_fault,
   input  wire logic                 csr_write,
   input  wire logic [IDX_W-1:0]     csr_index,
   input  wire logic [QW-1:0]        csr_data,
   output int                        errors,
   output int                        pending
);

   typedef struct packed {
      logic signed [QW-1:0] position;
      logic signed [QW-1:0] rate;
      logic                 fault;
   } estimate_type;

   estimate_type estimate_q[$];

   longint f_a, f_b, f_c, f_d, q_pos, q_cross, q_rate, r_meas;
   longint x_pos, x_rate;
   longint cov[4];

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul16(input longint a, input longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   function automatic estimate_type kalman_step(input longint z);
      longint xp0, xp1, s, k0, k1, y;
      longint fp[4];
      longint pp[4];
      estimate_type e;
      xp0 = clamp32(qmul16(f_a, x_pos) + qmul16(f_b, x_rate));
      xp1 = clamp32(qmul16(f_c, x_pos) + qmul16(f_d, x_rate));
      fp[0] = clamp32(qmul16(f_a, cov[0]) + qmul16(f_b, cov[2]));
      fp[1] = clamp32(qmul16(f_a, cov[1]) + qmul16(f_b, cov[3]));
      fp[2] = clamp32(qmul16(f_c, cov[0]) + qmul16(f_d, cov[2]));
      fp[3] = clamp32(qmul16(f_c, cov[1]) + qmul16(f_d, cov[3]));
      pp[0] = clamp32(qmul16(fp[0], f_a) + qmul16(fp[1], f_b) + q_pos);
      pp[1] = clamp32(qmul16(fp[0], f_c) + qmul16(fp[1], f_d) + q_cross);
      pp[2] = clamp32(qmul16(fp[2], f_a) + qmul16(fp[3], f_b) + q_cross);
      pp[3] = clamp32(qmul16(fp[2], f_c) + qmul16(fp[3], f_d) + q_rate);
      s = pp[0] + r_meas;
      e.fault = (s == 0);
      if (s == 0) begin
         k0 = 0;
         k1 = 0;
      end else begin
         k0 = clamp32((pp[0] * 64'sd65536) / s);
         k1 = clamp32((pp[2] * 64'sd65536) / s);
      end
      y = clamp32(z - xp0);
      x_pos = clamp32(xp0 + qmul16(k0, y));
      x_rate = clamp32(xp1 + qmul16(k1, y));
      cov[0] = clamp32(pp[0] - qmul16(k0, pp[0]));
      cov[1] = clamp32(pp[1] - qmul16(k0, pp[1]));
      cov[2] = clamp32(pp[2] - qmul16(k1, pp[0]));
      cov[3] = clamp32(pp[3] - qmul16(k1, pp[1]));
      e.position = x_pos[QW-1:0];
      e.rate = x_rate[QW-1:0];
      return e;
   endfunction

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         errors = 0;
         f_a = 13;
         f_b = 0;
         f_c = 0;
         f_d = 65536;
         q_pos = 7;
         q_cross = 328;
         q_rate = 16384;
         r_meas = 26214;
         x_pos = 0;
         x_rate = 0;
         for (int i = 0; i < 4; i++) cov[i] = 0;
         estimate_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_TRANS_A:     f_a = longint'($signed(csr_data));
               REG_TRANS_B:     f_b = longint'($signed(csr_data));
               REG_TRANS_C:     f_c = longint'($signed(csr_data));
               REG_TRANS_D:     f_d = longint'($signed(csr_data));
               REG_NOISE_POS:   q_pos = longint'({1'b0, csr_data[QW-2:0]});
               REG_NOISE_CROSS: q_cross = longint'($signed(csr_data));
               REG_NOISE_RATE:  q_rate = longint'({1'b0, csr_data[QW-2:0]});
               REG_MEAS_NOISE:  r_meas = longint'({1'b0, csr_data[QW-2:0]});
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (estimate_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result pos=%0d rate=%0d fault=%0b", $time,
                        rsp_est_position, rsp_est_rate, rsp_gain_fault);
            end else begin
               want = estimate_q.pop_front();
               if (rsp_est_position !== want.position) begin
                  errors++;
                  $display("%0t: est_position expected %0d actual %0d", $time,
                           want.position, rsp_est_position);
               end
               if (rsp_est_rate !== want.rate) begin
                  errors++;
                  $display("%0t: est_rate expected %0d actual %0d", $time,
                           want.rate, rsp_est_rate);
               end
               if (rsp_gain_fault !== want.fault) begin
                  errors++;
                  $display("%0t: gain_fault expected %0b actual %0b", $time,
                           want.fault, rsp_gain_fault);
               end
            end
         end
         if (req_valid && !req_stall) begin
            estimate_q.push_back(kalman_step(longint'(req_sample)));
         end
      end
      pending <= estimate_q.size();
   end

endmodule

// ===== sim/tb_kalman_filter_two_state.sv =====
`timescale 1ns / 100ps
module tb_kalman_filter_two_state
   import kf2s_pkg::*;
();

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [QW-1:0] req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [QW-1:0] rsp_est_position;
   logic signed [QW-1:0] rsp_est_rate;
   logic                 rsp_gain_fault;
   logic                 csr_write = 1'b0;
   logic [IDX_W-1:0]     csr_index = '0;
   logic [QW-1:0]        csr_data = '0;
   int                   errors;
   int                   pending;
   int                   burst_left = 0;
   logic signed [QW-1:0] track_pos = '0;
   logic signed [QW-1:0] track_rate = '0;

   kalman_filter_two_state u_dut (.*);

   kf2s_checker u_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // The receiver stalls in random modes, and once holds off long enough for
   // the block to fill up and stall its input.
   initial begin
      int mode, len, cycles;
      bit held;
      cycles = 0;
      held = 0;
      forever begin
         mode = $urandom_range(0, 3);
         len = $urandom_range(1, 60);
         if (!held && cycles > 6000) begin
            held = 1;
            mode = 4;
            len = 800;
         end
         repeat (len) begin
            @(posedge clock);
            cycles++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= $urandom_range(0, 1);
               3: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [QW-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
   endtask

   task automatic set_config(input logic [QW-1:0] a, b, c, d, qp, qc, qr, r);
      wait_drained();
      write_reg(REG_TRANS_A, a);
      write_reg(REG_TRANS_B, b);
      write_reg(REG_TRANS_C, c);
      write_reg(REG_TRANS_D, d);
      write_reg(REG_NOISE_POS, qp);
      write_reg(REG_NOISE_CROSS, qc);
      write_reg(REG_NOISE_RATE, qr);
      write_reg(REG_MEAS_NOISE, r);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Drives one item and returns at the edge that accepts it. Between bursts
   // the valid drops for a random gap.
   task automatic send_item(input logic signed [QW-1:0] val);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            @(posedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 30)) @(posedge clock);
         end
      end
      burst_left--;
      if (!req_valid || !csr_write) @(posedge clock);
      req_valid <= 1'b1;
      req_sample <= val;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic signed [QW-1:0] random_sample();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode == 0) return $urandom;
      if (mode == 1) return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      track_rate = track_rate + $signed(32'($urandom_range(0, 8191))) - 4096;
      track_pos = track_pos + (track_rate >>> 4);
      return track_pos + $signed(32'($urandom_range(0, 131071))) - 65536;
   endfunction

   function automatic logic [QW-1:0] random_coeff();
      if ($urandom_range(0, 1) != 0) return $urandom;
      return 32'($urandom_range(0, 131072)) + 32'hFFFF0000;
   endfunction

   initial begin
      logic signed [QW-1:0] directed[] = '{
         32'sd0, 32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 32'sd1, 32'sd65536,
         -32'sd65536, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
         32'sd131072, 32'sd196608, 32'sd262144, 32'sh55555555, 32'shAAAAAAAA};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_config(32'd65536, 32'd1311, 32'd0, 32'd65536, 32'd7, 32'd328, 32'd16384,
                 32'd26214);
      foreach (directed[i]) send_item(directed[i]);

      // Zero innovation variance: everything zero forces the gain to zero.
      set_config('0, '0, '0, '0, '0, '0, '0, '0);
      repeat (4) send_item($urandom);

      // Largest values, with the unused top bits of the noise registers set.
      set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
                 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      for (int i = 0; i < 60; i++) send_item(random_sample());

      set_config(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000);
      for (int i = 0; i < 60; i++) send_item(random_sample());

      set_config(32'd65536, 32'd1311, 32'd0, 32'd65536, 32'd7, 32'd328, 32'd16384,
                 32'd26214);
      for (int i = 0; i < 400; i++) begin
         if (i == 150) wait_drained();
         send_item(random_sample());
      end

      for (int p = 0; p < 6; p++) begin
         if (p % 2 == 0) begin
            set_config(32'd65536 + 32'($urandom_range(0, 2000)) - 32'd1000,
                       32'($urandom_range(0, 4000)), 32'($urandom_range(0, 300)),
                       32'd65536, 32'($urandom_range(0, 500)), $urandom_range(0, 2000),
                       32'($urandom_range(0, 70000)), 32'($urandom_range(0, 200000)));
         end else begin
            set_config(random_coeff(), random_coeff(), random_coeff(), random_coeff(),
                       $urandom, $urandom, $urandom,
                       ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
         end
         for (int i = 0; i < 180; i++) send_item(random_sample());
      end

      wait_drained();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/kf2s_pkg.sv
hdl/kf2s_div.sv
hdl/kf2s_datapath.sv
hdl/kf2s_ctrl.sv
hdl/kalman_filter_two_state.sv
sim/kf2s_checker.sv
sim/tb_kalman_filter_two_state.sv
